FILE: rtl/des_pkg.sv
// des package: permutation tables, s-boxes, weak key list and round helpers
package des_pkg;

  localparam int ROUNDS  = 16;
  localparam int N_WEAK  = 16;

  localparam logic [63:0] PARITY_MASK = 64'hFEFE_FEFE_FEFE_FEFE;

  localparam logic [6:0] IP_TAB [64] = '{
    7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,7'd10,7'd2,
    7'd60,7'd52,7'd44,7'd36,7'd28,7'd20,7'd12,7'd4,
    7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,7'd14,7'd6,
    7'd64,7'd56,7'd48,7'd40,7'd32,7'd24,7'd16,7'd8,
    7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9,7'd1,
    7'd59,7'd51,7'd43,7'd35,7'd27,7'd19,7'd11,7'd3,
    7'd61,7'd53,7'd45,7'd37,7'd29,7'd21,7'd13,7'd5,
    7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15,7'd7};

  localparam logic [6:0] FP_TAB [64] = '{
    7'd40,7'd8,7'd48,7'd16,7'd56,7'd24,7'd64,7'd32,
    7'd39,7'd7,7'd47,7'd15,7'd55,7'd23,7'd63,7'd31,
    7'd38,7'd6,7'd46,7'd14,7'd54,7'd22,7'd62,7'd30,
    7'd37,7'd5,7'd45,7'd13,7'd53,7'd21,7'd61,7'd29,
    7'd36,7'd4,7'd44,7'd12,7'd52,7'd20,7'd60,7'd28,
    7'd35,7'd3,7'd43,7'd11,7'd51,7'd19,7'd59,7'd27,
    7'd34,7'd2,7'd42,7'd10,7'd50,7'd18,7'd58,7'd26,
    7'd33,7'd1,7'd41,7'd9,7'd49,7'd17,7'd57,7'd25};

  localparam logic [5:0] E_TAB [48] = '{
    6'd32,6'd1,6'd2,6'd3,6'd4,6'd5, 6'd4,6'd5,6'd6,6'd7,6'd8,6'd9,
    6'd8,6'd9,6'd10,6'd11,6'd12,6'd13, 6'd12,6'd13,6'd14,6'd15,6'd16,6'd17,
    6'd16,6'd17,6'd18,6'd19,6'd20,6'd21, 6'd20,6'd21,6'd22,6'd23,6'd24,6'd25,
    6'd24,6'd25,6'd26,6'd27,6'd28,6'd29, 6'd28,6'd29,6'd30,6'd31,6'd32,6'd1};

  localparam logic [5:0] P_TAB [32] = '{
    6'd16,6'd7,6'd20,6'd21,6'd29,6'd12,6'd28,6'd17,
    6'd1,6'd15,6'd23,6'd26,6'd5,6'd18,6'd31,6'd10,
    6'd2,6'd8,6'd24,6'd14,6'd32,6'd27,6'd3,6'd9,
    6'd19,6'd13,6'd30,6'd6,6'd22,6'd11,6'd4,6'd25};

  localparam logic [6:0] PC1_TAB [56] = '{
    7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9,
    7'd1,7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,
    7'd10,7'd2,7'd59,7'd51,7'd43,7'd35,7'd27,
    7'd19,7'd11,7'd3,7'd60,7'd52,7'd44,7'd36,
    7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15,
    7'd7,7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,
    7'd14,7'd6,7'd61,7'd53,7'd45,7'd37,7'd29,
    7'd21,7'd13,7'd5,7'd28,7'd20,7'd12,7'd4};

  localparam logic [5:0] PC2_TAB [48] = '{
    6'd14,6'd17,6'd11,6'd24,6'd1,6'd5, 6'd3,6'd28,6'd15,6'd6,6'd21,6'd10,
    6'd23,6'd19,6'd12,6'd4,6'd26,6'd8, 6'd16,6'd7,6'd27,6'd20,6'd13,6'd2,
    6'd41,6'd52,6'd31,6'd37,6'd47,6'd55, 6'd30,6'd40,6'd51,6'd45,6'd33,6'd48,
    6'd44,6'd49,6'd39,6'd56,6'd34,6'd53, 6'd46,6'd42,6'd50,6'd36,6'd29,6'd32};

  localparam logic [1:0] SHIFT_TAB [16] = '{
    2'd1,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1};

  localparam logic [3:0] SBOX [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

  localparam logic [63:0] WEAK_KEY_TAB [N_WEAK] = '{
    64'h0000000000000000, 64'hFEFEFEFEFEFEFEFE,
    64'h1E1E1E1E0E0E0E0E, 64'hE0E0E0E0F0F0F0F0,
    64'h00FE00FE00FE00FE, 64'hFE00FE00FE00FE00,
    64'h1EE01EE00EF00EF0, 64'hE01EE01EF00EF00E,
    64'h00E000E000F000F0, 64'hE000E000F000F000,
    64'h1EFE1EFE0EFE0EFE, 64'hFE1EFE1EFE0EFE0E,
    64'h001E001E000E000E, 64'h1E001E000E000E00,
    64'hE0FEE0FEF0FEF0FE, 64'hFEE0FEE0FEF0FEF0};

  function automatic logic [63:0] ip_perm(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[6'(64 - int'(IP_TAB[i]))];
    return r;
  endfunction

  function automatic logic [63:0] fp_perm(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[6'(64 - int'(FP_TAB[i]))];
    return r;
  endfunction

  function automatic logic [55:0] pc1_perm(input logic [63:0] v);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = v[6'(64 - int'(PC1_TAB[i]))];
    return r;
  endfunction

  function automatic logic [47:0] pc2_perm(input logic [55:0] v);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = v[6'(56 - int'(PC2_TAB[i]))];
    return r;
  endfunction

  function automatic logic [27:0] rol28(input logic [27:0] v, input logic [1:0] n);
    logic [27:0] r;
    r = (n == 2'd2) ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
    return r;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] x;
    logic [5:0]  six;
    logic [31:0] s;
    logic [31:0] p;
    for (int i = 0; i < 48; i++) x[47-i] = r[5'(32 - int'(E_TAB[i]))];
    x = x ^ k;
    for (int b = 0; b < 8; b++) begin
      six = x[47-6*b -: 6];
      s[31-4*b -: 4] = SBOX[b][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[5'(32 - int'(P_TAB[i]))];
    return p;
  endfunction

endpackage

FILE: rtl/des_block_cipher.sv
// des_block_cipher: single-des engine, one block per clock unless the output stalls
//
// usage
//   s_axis_* carries one 64-bit block per transaction (first byte in bits 63:56).
//   m_axis_* returns the transformed block in tdata and the weak key flag in tuser.
//   key (index 0) and decrypt_mode (index 1) are written through cfg_we,
//   cfg_index and cfg_data while the engine holds no blocks.
// timing
//   two register stages: an input register and a result register, with the
//   sixteen rounds and the key schedule as logic between them. a block moves
//   from the input register to the result register; one block per cycle is
//   sustained while m_axis_tready stays high.
// reset
//   rst clears both stages and sets key and mode to zero (encrypt).
// stalls
//   while m_axis_tready is low the result holds, the input stage keeps its
//   block once the result stage is full; s_axis_tready drops only when both are full.
module des_block_cipher
  import des_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // block_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // block_out
  output logic        m_axis_tuser,   // key_is_weak
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic CFG_KEY  = 1'b0;
  localparam logic CFG_MODE = 1'b1;

  logic [63:0] key;
  logic        decrypt_mode;
  logic        in_valid;
  logic [63:0] in_block;
  logic        out_valid;
  logic [63:0] out_block;
  logic        out_weak;
  logic        adv_out;
  logic        take_in;

  logic [47:0] rkey [ROUNDS];
  logic [63:0] result_next;
  logic        weak_next;

  assign adv_out       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv_out;
  assign take_in       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key          <= '0;
      decrypt_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY:  key          <= cfg_data;
        CFG_MODE: decrypt_mode <= cfg_data[0];
        default:  ;
      endcase
    end
  end

  // key schedule
  always_comb begin
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    cd = pc1_perm(key);
    c  = cd[55:28];
    d  = cd[27:0];
    for (int i = 0; i < ROUNDS; i++) begin
      c = rol28(c, SHIFT_TAB[i]);
      d = rol28(d, SHIFT_TAB[i]);
      rkey[i] = pc2_perm({c, d});
    end
  end

  // feistel network
  always_comb begin
    logic [63:0] b;
    logic [31:0] lh;
    logic [31:0] rh;
    logic [31:0] t;
    logic [47:0] k;
    b  = ip_perm(in_block);
    lh = b[63:32];
    rh = b[31:0];
    for (int i = 0; i < ROUNDS; i++) begin
      k  = decrypt_mode ? rkey[ROUNDS-1-i] : rkey[i];
      t  = lh ^ feistel(rh, k);
      lh = rh;
      rh = t;
    end
    result_next = fp_perm({rh, lh});
  end

  always_comb begin
    weak_next = 1'b0;
    for (int i = 0; i < N_WEAK; i++)
      if ((key & PARITY_MASK) == WEAK_KEY_TAB[i]) weak_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take_in)
        in_valid <= 1'b1;
      else if (adv_out)
        in_valid <= 1'b0;
      if (adv_out)
        out_valid <= 1'b1;
      else if (m_axis_tready)
        out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) in_block <= s_axis_tdata;
    if (adv_out) begin
      out_block <= result_next;
      out_weak  <= weak_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_block;
  assign m_axis_tuser  = out_weak;

`ifndef SYNTH
  a_adv_fills_out: assert property (@(posedge clk) disable iff (rst)
    adv_out |=> out_valid)
    else $error("result stage not loaded");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready && !adv_out) |=> (out_valid && $stable(out_block)))
    else $error("stalled result changed");
  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!in_valid || !out_valid || m_axis_tready))
    else $error("input ready wrong");
`endif

endmodule

FILE: test/tb.sv
// testbench for des_block_cipher: stream traffic checked against an in-bench des predictor
module tb;
  import des_pkg::*;

  typedef enum logic {REG_KEY = 1'b0, REG_MODE = 1'b1} reg_idx_t;

  typedef struct packed {
    logic [63:0] block;
    logic        key_weak;
  } cipher_res_t;

  localparam int WATCHDOG_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [63:0] cfg_data = '0;

  logic [63:0] cur_key = '0;
  logic        cur_decrypt = 1'b0;
  cipher_res_t cipher_q[$];
  int          err_count = 0;
  int          hold_cycles = 0;
  bit          busy_mode = 1'b0;
  int          quiet = 0;

  des_block_cipher dut (.*);

  always #5 clk = ~clk;

  function automatic logic [31:0] round_func(logic [31:0] r, logic [47:0] k);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(E_TAB[i])];
    x ^= k;
    for (int b = 0; b < 8; b++) begin
      six = x[47-6*b -: 6];
      s[31-4*b -: 4] = SBOX[b][int'({six[5], six[0]}) * 16 + int'(six[4:1])];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32 - int'(P_TAB[i])];
    return p;
  endfunction

  function automatic cipher_res_t des_predict(logic [63:0] k, logic dec, logic [63:0] blk);
    logic [55:0] cd;
    logic [55:0] cdr;
    logic [27:0] c, d;
    logic [47:0] rk[16];
    logic [63:0] perm;
    logic [63:0] outb;
    logic [31:0] lh, rh, t;
    int          sh;
    cipher_res_t res;
    for (int i = 0; i < 56; i++) cd[55-i] = k[64 - int'(PC1_TAB[i])];
    c = cd[55:28];
    d = cd[27:0];
    for (int i = 0; i < 16; i++) begin
      sh = int'(SHIFT_TAB[i]);
      c = (c << sh) | (c >> (28 - sh));
      d = (d << sh) | (d >> (28 - sh));
      cdr = {c, d};
      for (int j = 0; j < 48; j++) rk[i][47-j] = cdr[56 - int'(PC2_TAB[j])];
    end
    for (int i = 0; i < 64; i++) perm[63-i] = blk[64 - int'(IP_TAB[i])];
    lh = perm[63:32];
    rh = perm[31:0];
    for (int i = 0; i < 16; i++) begin
      t  = lh ^ round_func(rh, dec ? rk[15-i] : rk[i]);
      lh = rh;
      rh = t;
    end
    perm = {rh, lh};
    for (int i = 0; i < 64; i++) outb[63-i] = perm[64 - int'(FP_TAB[i])];
    res.block    = outb;
    res.key_weak = 1'b0;
    for (int i = 0; i < N_WEAK; i++)
      if ((k & PARITY_MASK) == WEAK_KEY_TAB[i]) res.key_weak = 1'b1;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (busy_mode || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random stalls, plus a forced hold-off when asked
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (pick_gap() == 0);
    end
  end

  // result checking
  cipher_res_t exp_res;
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (cipher_q.size() == 0) begin
        $error("unexpected transaction: block_out %h", m_axis_tdata);
        err_count++;
      end else begin
        exp_res = cipher_q.pop_front();
        if (m_axis_tdata !== exp_res.block) begin
          $error("block_out: expected %h, actual %h", exp_res.block, m_axis_tdata);
          err_count++;
        end
        if (m_axis_tuser !== exp_res.key_weak) begin
          $error("key_is_weak: expected %b, actual %b", exp_res.key_weak, m_axis_tuser);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic send_block(logic [63:0] blk);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= blk;
    do @(posedge clk); while (!s_axis_tready);
    cipher_q.push_back(des_predict(cur_key, cur_decrypt, blk));
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_KEY) cur_key = val;
    else cur_decrypt = val[0];
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    send_block(64'h0);
    send_block('1);
    write_reg(REG_KEY, 64'h1334_5779_9BBC_DFF1);
    send_block(64'h0123_4567_89AB_CDEF);
    send_block(64'hAAAA_AAAA_AAAA_AAAA);
    send_block(64'h5555_5555_5555_5555);
    // flipped parity bits must not change anything
    write_reg(REG_KEY, 64'h1334_5779_9BBC_DFF1 ^ 64'h0101_0101_0101_0101);
    send_block(64'h0123_4567_89AB_CDEF);
    // only bit 0 of the mode write counts
    write_reg(REG_MODE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(64'h85E8_1354_0F0A_B405);
    send_block('1);
    write_reg(REG_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
    send_block(64'h8000_0000_0000_0001);
    write_reg(REG_KEY, '1);
    send_block(64'h0);
    write_reg(REG_KEY, 64'hFFFF_FFFF_FFFF_FFFE);
    send_block(64'h1);
  endtask

  task automatic test_weak_keys();
    for (int i = 0; i < N_WEAK; i++) begin
      write_reg(REG_KEY, WEAK_KEY_TAB[i] | (rand64() & ~PARITY_MASK));
      write_reg(REG_MODE, 64'($urandom_range(0, 1)));
      send_block(rand64());
    end
    // one bit off a weak key
    write_reg(REG_KEY, WEAK_KEY_TAB[1] ^ 64'h0200_0000_0000_0000);
    send_block(rand64());
  endtask

  task automatic test_random();
    logic [63:0] k;
    logic [63:0] b;
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: k = rand64();
        1: k = WEAK_KEY_TAB[$urandom_range(0, N_WEAK - 1)] | (rand64() & ~PARITY_MASK);
        2: k = (ph < 6) ? 64'h0 : '1;
        default: k = rand64() & (rand64() | 64'h0101_0101_0101_0101);
      endcase
      write_reg(REG_KEY, k);
      write_reg(REG_MODE, rand64());
      busy_mode = (ph % 3 == 2);
      for (int n = 0; n < 95; n++) begin
        case ($urandom_range(0, 9))
          0: b = '0;
          1: b = '1;
          2: b = 64'h1 << $urandom_range(0, 63);
          default: b = rand64();
        endcase
        send_block(b);
      end
      busy_mode = 1'b0;
    end
  endtask

  task automatic test_backpressure();
    write_reg(REG_KEY, rand64());
    write_reg(REG_MODE, 64'h0);
    hold_cycles = 300;
    busy_mode = 1'b1;
    for (int n = 0; n < 30; n++) send_block(rand64());
    busy_mode = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_weak_keys();
    test_backpressure();
    test_random();
    drain();
    repeat (5) @(posedge clk);
    if (err_count == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

FILE: sim.f
rtl/des_pkg.sv
rtl/des_block_cipher.sv
test/tb.sv
